// File: hw/rtl/ubx_frame_deframer_unit_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef UBX_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define UBX_FRAME_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define UBXDF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define UBXDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer next-cycle check failed");

`endif

// File: hw/rtl/ubxdf_pkg.sv
// Shared types and constants of the frame deframer.
package ubxdf_pkg;

   localparam logic [7:0]  SYNC_FIRST    = 8'hB5;
   localparam logic [7:0]  SYNC_SECOND   = 8'h62;
   localparam logic [15:0] MAX_LEN_RESET = 16'd512;

   localparam logic [1:0] STATUS_NONE    = 2'd0;
   localparam logic [1:0] STATUS_GOOD    = 2'd1;
   localparam logic [1:0] STATUS_BAD_SUM = 2'd2;
   localparam logic [1:0] STATUS_BAD_LEN = 2'd3;

   typedef struct packed {
      logic        payload_valid;
      logic [15:0] payload_index;
      logic [7:0]  payload_byte;
      logic [1:0]  frame_status;
      logic [7:0]  msg_class;
      logic [7:0]  msg_id;
      logic [15:0] frame_length;
   } result_type;

endpackage

// File: hw/rtl/ubxdf_ifs.sv
// Channel interfaces of the frame deframer: byte input, result output, length limit write.
interface ubxdf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ubxdf_rsp_if;
   logic        valid;
   logic        ready;
   logic        payload_valid;
   logic [15:0] payload_index;
   logic [7:0]  payload_byte;
   logic [1:0]  frame_status;
   logic [7:0]  msg_class;
   logic [7:0]  msg_id;
   logic [15:0] frame_length;
   modport source (output valid, output payload_valid, output payload_index,
                   output payload_byte, output frame_status, output msg_class,
                   output msg_id, output frame_length, input ready);
   modport sink   (input valid, input payload_valid, input payload_index,
                   input payload_byte, input frame_status, input msg_class,
                   input msg_id, input frame_length, output ready);
endinterface

interface ubxdf_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] max_payload_length;
   modport source (output valid, output max_payload_length, input ready);
   modport sink   (input valid, input max_payload_length, output ready);
endinterface

// File: hw/rtl/ubxdf_parser.sv
// Frame state machine and 8-bit Fletcher checksum; builds one result per accepted byte.
`include "ubx_frame_deframer_unit_macros.svh"

module ubxdf_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             rx_byte,
   input  logic [15:0]            max_len,
   output ubxdf_pkg::result_type  result
);
   import ubxdf_pkg::*;

   localparam logic [3:0] STEP_HUNT   = 4'd0;
   localparam logic [3:0] STEP_SYNC2  = 4'd1;
   localparam logic [3:0] STEP_CLASS  = 4'd2;
   localparam logic [3:0] STEP_ID     = 4'd3;
   localparam logic [3:0] STEP_LEN_LO = 4'd4;
   localparam logic [3:0] STEP_LEN_HI = 4'd5;
   localparam logic [3:0] STEP_DATA   = 4'd6;
   localparam logic [3:0] STEP_CK_A   = 4'd7;
   localparam logic [3:0] STEP_CK_B   = 4'd8;

   logic [3:0]  step_ff, step_in;
   logic [7:0]  class_ff, class_in;
   logic [7:0]  id_ff, id_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;
   logic [7:0]  acc_a;
   logic [7:0]  acc_b;
   logic [15:0] len_full;
   logic [15:0] count_inc;

   // Running Fletcher sums with this byte folded in.
   assign acc_a     = sum_a_ff + rx_byte;
   assign acc_b     = sum_b_ff + acc_a;
   assign len_full  = {rx_byte, length_ff[7:0]};
   assign count_inc = count_ff + 16'd1;

   always_comb begin
      step_in   = step_ff;
      class_in  = class_ff;
      id_in     = id_ff;
      length_in = length_ff;
      count_in  = count_ff;
      sum_a_in  = sum_a_ff;
      sum_b_in  = sum_b_ff;
      result    = '0;
      unique case (step_ff)
         STEP_SYNC2: begin
            if (rx_byte == SYNC_SECOND) begin
               step_in = STEP_CLASS;
            end else if (rx_byte == SYNC_FIRST) begin
               step_in = STEP_SYNC2;
            end else begin
               step_in = STEP_HUNT;
            end
         end
         STEP_CLASS: begin
            class_in = rx_byte;
            sum_a_in = rx_byte;
            sum_b_in = rx_byte;
            step_in  = STEP_ID;
         end
         STEP_ID: begin
            sum_a_in = acc_a;
            sum_b_in = acc_b;
            id_in    = rx_byte;
            step_in  = STEP_LEN_LO;
         end
         STEP_LEN_LO: begin
            sum_a_in  = acc_a;
            sum_b_in  = acc_b;
            length_in = {8'd0, rx_byte};
            step_in   = STEP_LEN_HI;
         end
         STEP_LEN_HI: begin
            sum_a_in  = acc_a;
            sum_b_in  = acc_b;
            length_in = len_full;
            count_in  = '0;
            if (len_full > max_len) begin
               result.frame_status = STATUS_BAD_LEN;
               step_in             = STEP_HUNT;
            end else if (len_full == 16'd0) begin
               step_in = STEP_CK_A;
            end else begin
               step_in = STEP_DATA;
            end
         end
         STEP_DATA: begin
            sum_a_in             = acc_a;
            sum_b_in             = acc_b;
            result.payload_valid = 1'b1;
            result.payload_index = count_ff;
            result.payload_byte  = rx_byte;
            count_in             = count_inc;
            if (count_inc == length_ff) begin
               step_in = STEP_CK_A;
            end
         end
         STEP_CK_A: begin
            if (rx_byte == sum_a_ff) begin
               step_in = STEP_CK_B;
            end else begin
               result.frame_status = STATUS_BAD_SUM;
               step_in             = STEP_HUNT;
            end
         end
         STEP_CK_B: begin
            result.frame_status = (rx_byte == sum_b_ff) ? STATUS_GOOD : STATUS_BAD_SUM;
            step_in             = STEP_HUNT;
         end
         default: begin
            step_in = (rx_byte == SYNC_FIRST) ? STEP_SYNC2 : STEP_HUNT;
         end
      endcase
      result.msg_class    = class_in;
      result.msg_id       = id_in;
      result.frame_length = length_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= STEP_HUNT;
         class_ff  <= '0;
         id_ff     <= '0;
         length_ff <= '0;
         count_ff  <= '0;
         sum_a_ff  <= '0;
         sum_b_ff  <= '0;
      end else if (accept) begin
         step_ff   <= step_in;
         class_ff  <= class_in;
         id_ff     <= id_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         sum_a_ff  <= sum_a_in;
         sum_b_ff  <= sum_b_in;
      end
   end

   `UBXDF_ASSERT_SAME(a_data_in_payload, clock, reset, result.payload_valid, step_ff == STEP_DATA)
   `UBXDF_ASSERT_SAME(a_index_below_len, clock, reset, result.payload_valid, count_ff < length_ff)
   `UBXDF_ASSERT_NEXT(a_status_ends_frame, clock, reset,
      accept && (result.frame_status != STATUS_NONE), step_ff == STEP_HUNT)

endmodule

// File: hw/rtl/ubxdf_out_stage.sv
// Result register between the parser and the result channel.
`include "ubx_frame_deframer_unit_macros.svh"

module ubxdf_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ubxdf_pkg::result_type in_result,
   ubxdf_rsp_if.source           rsp_chan
);
   import ubxdf_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;
   logic       load;

   // The register frees up in the same cycle its item is taken.
   assign in_ready = !valid_ff || rsp_chan.ready;
   assign load     = in_valid && in_ready;
   assign valid_in = load || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= in_result;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.payload_valid = data_ff.payload_valid;
   assign rsp_chan.payload_index = data_ff.payload_index;
   assign rsp_chan.payload_byte  = data_ff.payload_byte;
   assign rsp_chan.frame_status  = data_ff.frame_status;
   assign rsp_chan.msg_class     = data_ff.msg_class;
   assign rsp_chan.msg_id        = data_ff.msg_id;
   assign rsp_chan.frame_length  = data_ff.frame_length;

   `UBXDF_ASSERT_NEXT(a_load_shows_item, clock, reset, load, valid_ff)

endmodule

// File: hw/rtl/ubx_frame_deframer_unit.sv
// Top level of the binary GNSS frame deframer.
// Usage:
//   req_chan carries one received serial byte per item. rsp_chan returns exactly one
//   item per input byte, in order: payload flag, index and byte, a frame status
//   (nothing, good, checksum failed, length rejected) and the class, id and
//   announced length of the current frame.
//   csr_chan writes the longest accepted payload length; it is always ready and
//   should be written only while no byte is in flight.
// Timing and throughput:
//   A byte accepted at one clock edge has its result registered on rsp_chan right after
//   that edge. One byte is accepted per cycle while rsp_chan keeps taking results; the
//   parser state and the checksum advance in a single step per byte.
// Reset:
//   Synchronous, active high. The parser hunts for the first sync byte, its frame
//   fields clear to zero, and the length limit returns to 512.
// Stalls:
//   While rsp_chan is not ready and a result is held, req_chan.ready is low; the
//   held item stays unchanged until taken, and nothing is dropped.
module ubx_frame_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   ubxdf_req_if.sink   req_chan,
   ubxdf_rsp_if.source rsp_chan,
   ubxdf_csr_if.sink   csr_chan
);
   import ubxdf_pkg::*;

   logic [15:0] max_len_ff;
   logic        out_ready;
   logic        accept;
   result_type  step_result;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = out_ready;
   assign accept         = req_chan.valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_chan.valid) begin
         max_len_ff <= csr_chan.max_payload_length;
      end
   end

   ubxdf_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_chan.rx_byte),
      .max_len (max_len_ff),
      .result  (step_result)
   );

   ubxdf_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (out_ready),
      .in_result (step_result),
      .rsp_chan  (rsp_chan)
   );

endmodule

// File: bench/ubx_frame_deframer_unit_test.sv
`timescale 1ns / 100ps
// Self-checking bench for the frame deframer: directed and random frames through a bit-true parser predictor.
module ubx_frame_deframer_unit_test;
   import ubxdf_pkg::*;

   typedef enum logic [3:0] {
      HUNT_SYNC1, HUNT_SYNC2, GET_CLASS, GET_ID, GET_LEN_LO, GET_LEN_HI,
      GET_PAYLOAD, GET_SUM_A, GET_SUM_B
   } parse_state_e;

   typedef enum {FRAME_GOOD, FRAME_BAD_SUM_A, FRAME_BAD_SUM_B} frame_kind_e;

   localparam int TIMEOUT_CYCLES = 1_000_000;
   localparam int MAX_REPORTS    = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   ubxdf_req_if req_chan ();
   ubxdf_rsp_if rsp_chan ();
   ubxdf_csr_if csr_chan ();

   ubx_frame_deframer_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Parser state as the block should hold it.
   parse_state_e parse_at;
   logic [7:0]   class_q, id_q, run_a, run_b;
   logic [15:0]  length_q, count_q, len_limit;

   logic [7:0]   byte_q[$];
   result_type   expected_q[$];

   int sender_idle_pct = 14;
   int recv_stall_pct  = 61;
   int hold_len        = 0;
   logic hold_toggle   = 1'b0;
   logic hold_seen;
   int hold_left;

   int cycle_count    = 0;
   int error_count    = 0;
   int accepted_bytes = 0;
   int good_frames    = 0;
   int bad_sum_frames = 0;
   int bad_len_frames = 0;
   int payload_bytes  = 0;

   function automatic result_type parse_byte(input logic [7:0] b);
      result_type r;
      r = '0;
      if (parse_at inside {GET_ID, GET_LEN_LO, GET_LEN_HI, GET_PAYLOAD}) begin
         run_a = run_a + b;
         run_b = run_b + run_a;
      end
      case (parse_at)
         HUNT_SYNC2: begin
            if (b == SYNC_SECOND)
               parse_at = GET_CLASS;
            else
               parse_at = (b == SYNC_FIRST) ? HUNT_SYNC2 : HUNT_SYNC1;
         end
         GET_CLASS: begin
            class_q  = b;
            run_a    = b;
            run_b    = b;
            parse_at = GET_ID;
         end
         GET_ID: begin
            id_q     = b;
            parse_at = GET_LEN_LO;
         end
         GET_LEN_LO: begin
            length_q = {8'h00, b};
            parse_at = GET_LEN_HI;
         end
         GET_LEN_HI: begin
            length_q = {b, length_q[7:0]};
            count_q  = '0;
            if (length_q > len_limit) begin
               r.frame_status = STATUS_BAD_LEN;
               parse_at       = HUNT_SYNC1;
            end else if (length_q == 16'd0) begin
               parse_at = GET_SUM_A;
            end else begin
               parse_at = GET_PAYLOAD;
            end
         end
         GET_PAYLOAD: begin
            r.payload_valid = 1'b1;
            r.payload_index = count_q;
            r.payload_byte  = b;
            count_q         = count_q + 16'd1;
            if (count_q == length_q)
               parse_at = GET_SUM_A;
         end
         GET_SUM_A: begin
            // A wrong first checksum byte ends the frame and is not a sync candidate.
            if (b == run_a) begin
               parse_at = GET_SUM_B;
            end else begin
               r.frame_status = STATUS_BAD_SUM;
               parse_at       = HUNT_SYNC1;
            end
         end
         GET_SUM_B: begin
            r.frame_status = (b == run_b) ? STATUS_GOOD : STATUS_BAD_SUM;
            parse_at       = HUNT_SYNC1;
         end
         default: begin
            parse_at = (b == SYNC_FIRST) ? HUNT_SYNC2 : HUNT_SYNC1;
         end
      endcase
      r.msg_class    = class_q;
      r.msg_id       = id_q;
      r.frame_length = length_q;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      end
   endfunction

   // Byte source: offers the next pending byte, predicts the result of each accepted one.
   always @(posedge clock) begin : byte_driver
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_q.push_back(parse_byte(req_chan.rx_byte));
            accepted_bytes++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (byte_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_chan.valid   <= 1'b1;
               req_chan.rx_byte <= byte_q.pop_front();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Result sink: checks each taken item against the oldest prediction.
   always @(posedge clock) begin : result_monitor
      result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_q.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $error("result item arrived with no prediction pending");
            end else begin
               want = expected_q.pop_front();
               check_field("payload_valid", 16'(want.payload_valid),
                           16'(rsp_chan.payload_valid));
               check_field("payload_index", want.payload_index, rsp_chan.payload_index);
               check_field("payload_byte", 16'(want.payload_byte),
                           16'(rsp_chan.payload_byte));
               check_field("frame_status", 16'(want.frame_status),
                           16'(rsp_chan.frame_status));
               check_field("msg_class", 16'(want.msg_class), 16'(rsp_chan.msg_class));
               check_field("msg_id", 16'(want.msg_id), 16'(rsp_chan.msg_id));
               check_field("frame_length", want.frame_length, rsp_chan.frame_length);
               if (want.payload_valid)
                  payload_bytes++;
               case (want.frame_status)
                  STATUS_GOOD:    good_frames++;
                  STATUS_BAD_SUM: bad_sum_frames++;
                  STATUS_BAD_LEN: bad_len_frames++;
                  default: ;
               endcase
            end
         end
         rsp_chan.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Long receiver hold-off, started by a toggle and counted down here.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_seen <= 1'b0;
      end else if (hold_toggle != hold_seen) begin
         hold_left <= hold_len;
         hold_seen <= hold_toggle;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= TIMEOUT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("ubx_frame_deframer_unit regression: fail");
         $finish;
      end
   end

   task automatic push_summed(input logic [7:0] b, inout logic [7:0] sa, inout logic [7:0] sb);
      byte_q.push_back(b);
      sa = sa + b;
      sb = sb + sa;
   endtask

   task automatic push_frame(input frame_kind_e kind, input logic [7:0] cls,
                             input logic [7:0] id, input logic [15:0] len);
      logic [7:0] sa;
      logic [7:0] sb;
      int i;
      sa = '0;
      sb = '0;
      byte_q.push_back(SYNC_FIRST);
      byte_q.push_back(SYNC_SECOND);
      push_summed(cls, sa, sb);
      push_summed(id, sa, sb);
      push_summed(len[7:0], sa, sb);
      push_summed(len[15:8], sa, sb);
      if (len > len_limit)
         return;
      for (i = 0; i < int'(len); i++)
         push_summed(8'($urandom), sa, sb);
      if (kind == FRAME_BAD_SUM_A) begin
         // About half the time, use a wrong byte that looks like a first sync.
         if (sa != SYNC_FIRST && $urandom_range(1) == 1)
            byte_q.push_back(SYNC_FIRST);
         else
            byte_q.push_back(sa ^ 8'($urandom_range(1, 255)));
         return;
      end
      byte_q.push_back(sa);
      if (kind == FRAME_BAD_SUM_B)
         byte_q.push_back(sb ^ 8'($urandom_range(1, 255)));
      else
         byte_q.push_back(sb);
   endtask

   function automatic logic [15:0] pick_length();
      int r;
      int top;
      r   = $urandom_range(99);
      top = (int'(len_limit) < 24) ? int'(len_limit) : 24;
      if (len_limit != 16'hFFFF && r < 4)
         return len_limit + 16'd1;
      if (len_limit != 16'hFFFF && r < 12)
         return 16'($urandom_range(int'(len_limit) + 1, 65535));
      if (len_limit <= 16'd64 && r < 20)
         return len_limit;
      if (r < 25)
         return 16'd0;
      return 16'($urandom_range(0, top));
   endfunction

   task automatic random_frames(input int target);
      int counted;
      int r;
      int size_mark;
      int i;
      logic [7:0] b;
      counted = 0;
      while (counted < target) begin
         r         = $urandom_range(99);
         size_mark = byte_q.size();
         if (r < 70) begin
            push_frame(FRAME_GOOD, 8'($urandom), 8'($urandom), pick_length());
         end else if (r < 78) begin
            push_frame(FRAME_BAD_SUM_A, 8'($urandom), 8'($urandom), pick_length());
         end else if (r < 86) begin
            push_frame(FRAME_BAD_SUM_B, 8'($urandom), 8'($urandom), pick_length());
         end else if (r < 93) begin
            b = 8'($urandom);
            if (b == SYNC_SECOND)
               b = SYNC_FIRST;
            byte_q.push_back(SYNC_FIRST);
            byte_q.push_back(b);
         end else begin
            // Line noise between frames; kept free of first sync bytes.
            for (i = 0; i < $urandom_range(1, 6); i++) begin
               b = 8'($urandom);
               byte_q.push_back((b == SYNC_FIRST) ? ~b : b);
            end
            continue;
         end
         counted += byte_q.size() - size_mark;
      end
   endtask

   task automatic wait_until_drained();
      do
         @(posedge clock);
      while (byte_q.size() != 0 || req_chan.valid || expected_q.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_length_limit(input logic [15:0] value);
      wait_until_drained();
      csr_chan.valid              <= 1'b1;
      csr_chan.max_payload_length <= value;
      do
         @(posedge clock);
      while (!(csr_chan.valid && csr_chan.ready));
      len_limit = value;
      csr_chan.valid <= 1'b0;
   endtask

   initial begin : stimulus
      req_chan.valid              = 1'b0;
      req_chan.rx_byte            = '0;
      rsp_chan.ready              = 1'b0;
      csr_chan.valid              = 1'b0;
      csr_chan.max_payload_length = '0;
      parse_at  = HUNT_SYNC1;
      class_q   = '0;
      id_q      = '0;
      length_q  = '0;
      count_q   = '0;
      run_a     = '0;
      run_b     = '0;
      len_limit = MAX_LEN_RESET;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: lone first sync, repeated first sync, empty payload, a wrong
      // first checksum byte followed by a stray second sync, an oversize length.
      byte_q.push_back(SYNC_FIRST);
      byte_q.push_back(8'h00);
      byte_q.push_back(SYNC_FIRST);
      push_frame(FRAME_GOOD, 8'hFF, 8'h00, 16'd0);
      push_frame(FRAME_BAD_SUM_A, 8'h00, 8'hFF, 16'd1);
      byte_q.push_back(SYNC_SECOND);
      push_frame(FRAME_GOOD, 8'h0A, 8'h55, 16'hFFFF);

      random_frames(150);
      hold_len    <= 300;
      hold_toggle <= ~hold_toggle;
      wait_until_drained();

      sender_idle_pct <= 61;
      recv_stall_pct  <= 14;
      write_length_limit(16'd0);
      random_frames(150);

      sender_idle_pct <= 0;
      recv_stall_pct  <= 0;
      write_length_limit(16'hFFFF);
      random_frames(150);

      write_length_limit(16'($urandom_range(1, 40)));
      random_frames(150);

      wait_until_drained();
      $display("Checked %0d bytes: %0d good frames, %0d checksum failures, %0d length rejects,",
               accepted_bytes, good_frames, bad_sum_frames, bad_len_frames);
      $display("%0d payload bytes, length limits 512, 0, 65535 and one small value.",
               payload_bytes);
      if (error_count == 0)
         $display("ubx_frame_deframer_unit regression: pass");
      else
         $display("ubx_frame_deframer_unit regression: fail");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/ubxdf_pkg.sv
hw/rtl/ubxdf_ifs.sv
hw/rtl/ubxdf_parser.sv
hw/rtl/ubxdf_out_stage.sv
hw/rtl/ubx_frame_deframer_unit.sv
bench/ubx_frame_deframer_unit_test.sv
